// ===== src/qrv_pkg.sv =====
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared widths for the quaternion vector rotation datapath and its channels.
// ----------------------------------------------------------------------------
package qrv_pkg;

    localparam int DEF_QUAT_WIDTH = 16;  // quaternion components, signed
    localparam int DEF_VEC_WIDTH  = 32;  // vector components, signed
    localparam int DEF_QUAT_FRAC  = 14;  // fraction bits of the quaternion
    localparam int ACC_LIMIT      = 64;  // sums wrap beyond this width

endpackage

// ===== src/qrv_in_if.sv =====
// ----------------------------------------------------------------------------
// qrv_in_if
// Input channel: one quaternion and one 3-vector per item, valid/ready.
// ----------------------------------------------------------------------------
interface qrv_in_if import qrv_pkg::*; #(
    parameter int QUAT_WIDTH = DEF_QUAT_WIDTH,
    parameter int VEC_WIDTH  = DEF_VEC_WIDTH
) ();

    logic                         valid;
    logic                         ready;
    logic signed [QUAT_WIDTH-1:0] quat_w;
    logic signed [QUAT_WIDTH-1:0] quat_i;
    logic signed [QUAT_WIDTH-1:0] quat_j;
    logic signed [QUAT_WIDTH-1:0] quat_k;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;

    modport source (
        output valid, quat_w, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_i, quat_j, quat_k, vec_x, vec_y, vec_z,
        output ready
    );

endinterface

// ===== src/qrv_out_if.sv =====
// ----------------------------------------------------------------------------
// qrv_out_if
// Output channel: rotated 3-vector and saturation flag per item, valid/ready.
// ----------------------------------------------------------------------------
interface qrv_out_if import qrv_pkg::*; #(
    parameter int VEC_WIDTH = DEF_VEC_WIDTH
) ();

    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        clipped;

    modport source (
        output valid, rot_x, rot_y, rot_z, clipped,
        input  ready
    );

    modport sink (
        input  valid, rot_x, rot_y, rot_z, clipped,
        output ready
    );

endinterface

// ===== src/quaternion_rotate_vector_unit.sv =====
// Four register stages (A to D) lie between input accept and result valid.
// Throughput: one item per cycle when not stalled; each of the two Hamilton
//   products has its own multiplier bank and adders, so items share nothing.
// Stalls back up stage by stage; an empty stage keeps the input ready.
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_unit
// Rotates a vector by a quaternion as the vector part of q * v * conj(q),
// with a floor shift after each product and saturation of the result.
// ----------------------------------------------------------------------------
module quaternion_rotate_vector_unit import qrv_pkg::*; #(
    parameter int QUAT_WIDTH = DEF_QUAT_WIDTH,
    parameter int VEC_WIDTH  = DEF_VEC_WIDTH,
    parameter int QUAT_FRAC  = DEF_QUAT_FRAC
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qrv_in_if.sink     i_in,
    qrv_out_if.source  o_out
);

    // first product q * (0, v)
    localparam int P1W = QUAT_WIDTH + VEC_WIDTH;
    localparam int S1F = P1W + 2;
    localparam int S1W = (S1F > ACC_LIMIT) ? ACC_LIMIT : S1F;
    localparam int TW  = (S1W - QUAT_FRAC > 1) ? S1W - QUAT_FRAC : 1;
    // second product t * conj(q)
    localparam int P2W = TW + QUAT_WIDTH;
    localparam int S2F = P2W + 2;
    localparam int S2W = (S2F > ACC_LIMIT) ? ACC_LIMIT : S2F;
    localparam int UW  = (S2W - QUAT_FRAC > 1) ? S2W - QUAT_FRAC : 1;

    localparam logic signed [VEC_WIDTH-1:0] VMAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
    localparam logic signed [VEC_WIDTH-1:0] VMIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

    logic [3:0] r_v;
    logic [3:0] w_adv;

    logic signed [QUAT_WIDTH-1:0] r_qa [4];
    logic signed [QUAT_WIDTH-1:0] r_qb [4];
    logic signed [P1W-1:0]        r_p1 [12];
    logic signed [TW-1:0]         r_t  [4];
    logic signed [P2W-1:0]        r_p2 [12];
    logic signed [VEC_WIDTH-1:0]  r_rot [3];
    logic                         r_clip;

    logic signed [S1F-1:0]        n_s1  [4];
    logic signed [S1W-1:0]        n_s1w [4];
    logic signed [S1W-1:0]        n_sh1 [4];
    logic signed [TW-1:0]         n_t   [4];
    logic signed [S2F-1:0]        n_s2  [3];
    logic signed [S2W-1:0]        n_s2w [3];
    logic signed [S2W-1:0]        n_sh2 [3];
    logic signed [UW-1:0]         n_u   [3];
    logic signed [VEC_WIDTH-1:0]  n_rot [3];
    logic [2:0]                   n_clip;

    // a stage may load when it is empty or the next one moves on
    assign w_adv[3] = ~r_v[3] | o_out.ready;
    assign w_adv[2] = ~r_v[2] | w_adv[3];
    assign w_adv[1] = ~r_v[1] | w_adv[2];
    assign w_adv[0] = ~r_v[0] | w_adv[1];

    assign i_in.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_adv[0]) r_v[0] <= i_in.valid;
            if (w_adv[1]) r_v[1] <= r_v[0];
            if (w_adv[2]) r_v[2] <= r_v[1];
            if (w_adv[3]) r_v[3] <= r_v[2];
        end
    end

    // stage A: q * v partial products
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_qa[0]  <= i_in.quat_w;
            r_qa[1]  <= i_in.quat_i;
            r_qa[2]  <= i_in.quat_j;
            r_qa[3]  <= i_in.quat_k;
            r_p1[0]  <= i_in.quat_i * i_in.vec_x;
            r_p1[1]  <= i_in.quat_j * i_in.vec_y;
            r_p1[2]  <= i_in.quat_k * i_in.vec_z;
            r_p1[3]  <= i_in.quat_w * i_in.vec_x;
            r_p1[4]  <= i_in.quat_j * i_in.vec_z;
            r_p1[5]  <= i_in.quat_k * i_in.vec_y;
            r_p1[6]  <= i_in.quat_w * i_in.vec_y;
            r_p1[7]  <= i_in.quat_i * i_in.vec_z;
            r_p1[8]  <= i_in.quat_k * i_in.vec_x;
            r_p1[9]  <= i_in.quat_w * i_in.vec_z;
            r_p1[10] <= i_in.quat_i * i_in.vec_y;
            r_p1[11] <= i_in.quat_j * i_in.vec_x;
        end
    end

    // stage B: sums of the first product, floor shift
    always_comb begin
        n_s1[0] = -r_p1[0] - r_p1[1] - r_p1[2];
        n_s1[1] = r_p1[3] + r_p1[4] - r_p1[5];
        n_s1[2] = r_p1[6] - r_p1[7] + r_p1[8];
        n_s1[3] = r_p1[9] + r_p1[10] - r_p1[11];
        for (int n = 0; n < 4; n++) begin
            n_s1w[n] = $signed(n_s1[n][S1W-1:0]);
            n_sh1[n] = n_s1w[n] >>> QUAT_FRAC;
            n_t[n]   = $signed(n_sh1[n][TW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            for (int n = 0; n < 4; n++) begin
                r_t[n]  <= n_t[n];
                r_qb[n] <= r_qa[n];
            end
        end
    end

    // stage C: t * conj(q) partial products, conjugate signs folded into sums
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_p2[0]  <= r_t[0] * r_qb[1];
            r_p2[1]  <= r_t[1] * r_qb[0];
            r_p2[2]  <= r_t[2] * r_qb[3];
            r_p2[3]  <= r_t[3] * r_qb[2];
            r_p2[4]  <= r_t[0] * r_qb[2];
            r_p2[5]  <= r_t[2] * r_qb[0];
            r_p2[6]  <= r_t[1] * r_qb[3];
            r_p2[7]  <= r_t[3] * r_qb[1];
            r_p2[8]  <= r_t[0] * r_qb[3];
            r_p2[9]  <= r_t[3] * r_qb[0];
            r_p2[10] <= r_t[1] * r_qb[2];
            r_p2[11] <= r_t[2] * r_qb[1];
        end
    end

    // stage D: vector part of the second product, shift, saturate
    always_comb begin
        n_s2[0] = -r_p2[0] + r_p2[1] - r_p2[2] + r_p2[3];
        n_s2[1] = -r_p2[4] + r_p2[5] + r_p2[6] - r_p2[7];
        n_s2[2] = -r_p2[8] + r_p2[9] - r_p2[10] + r_p2[11];
        for (int n = 0; n < 3; n++) begin
            n_s2w[n] = $signed(n_s2[n][S2W-1:0]);
            n_sh2[n] = n_s2w[n] >>> QUAT_FRAC;
            n_u[n]   = $signed(n_sh2[n][UW-1:0]);
        end
    end

    generate
        if (UW > VEC_WIDTH) begin : g_sat
            always_comb begin
                for (int n = 0; n < 3; n++) begin
                    // in range when all bits above the result's sign agree with it
                    n_clip[n] = ~((&n_u[n][UW-1:VEC_WIDTH-1]) |
                                  (~|n_u[n][UW-1:VEC_WIDTH-1]));
                    if (!n_clip[n]) begin
                        n_rot[n] = $signed(n_u[n][VEC_WIDTH-1:0]);
                    end else if (n_u[n][UW-1]) begin
                        n_rot[n] = VMIN;
                    end else begin
                        n_rot[n] = VMAX;
                    end
                end
            end
        end else begin : g_ext
            always_comb begin
                for (int n = 0; n < 3; n++) begin
                    n_clip[n] = 1'b0;
                    n_rot[n]  = VEC_WIDTH'(n_u[n]);
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            for (int n = 0; n < 3; n++) begin
                r_rot[n] <= n_rot[n];
            end
            r_clip <= |n_clip;
        end
    end

    assign o_out.valid   = r_v[3];
    assign o_out.rot_x   = r_rot[0];
    assign o_out.rot_y   = r_rot[1];
    assign o_out.rot_z   = r_rot[2];
    assign o_out.clipped = r_clip;

    // an accepted item always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_v[0])
        else $error("accepted item not captured in stage A");

    // any bubble in the pipe must let a new item in
    a_bubble_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_v) |-> i_in.ready)
        else $error("input stalled with an empty stage");

    // a held stage keeps its item until the next one moves
    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !w_adv[3] |=> r_v[2] && r_v[3])
        else $error("item dropped from stage C during a stall");

    // the clip flag only goes with a saturated component
    a_clip_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.clipped |->
            (o_out.rot_x == VMAX) || (o_out.rot_x == VMIN) ||
            (o_out.rot_y == VMAX) || (o_out.rot_y == VMIN) ||
            (o_out.rot_z == VMAX) || (o_out.rot_z == VMIN))
        else $error("clip flag set without a saturated component");

endmodule
